@@ rtl/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, widths and helpers for the Chebyshev series evaluator.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned NUM_COEFS_DEF = 32;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ORD_W     = 5;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // shared multiplier: signed 33x33, so 32-bit unsigned operands fit
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam int unsigned ACC_W   = 80;  // accumulator, also holds |sum| * inv_half_span
  localparam int unsigned RES_W   = 64;  // rounded result before 32-bit clip
  localparam int unsigned T_W     = 28;  // t, signed, 26 fraction bits
  localparam int unsigned BASIS_W = 32;  // T_k / U_k, signed, 26 fraction bits
  localparam int unsigned TERM_W  = 40;  // rounded derivative term
  localparam int unsigned FRAC_T  = 26;

  localparam logic signed [BASIS_W-1:0] BASIS_ONE = 32'sh0400_0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_VALUE = 2'd1,
    REQ_DERIV = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER         = 2'd0,
    CFG_X_MIN         = 2'd1,
    CFG_X_MAX         = 2'd2,
    CFG_INV_HALF_SPAN = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_MAP1,
    S_MAP2,
    S_MAP3,
    S_TERM,
    S_ACC,
    S_ACCK,
    S_REC,
    S_REC2,
    S_VRND,
    S_DABS,
    S_DMLO,
    S_DMHI,
    S_DSUM,
    S_DRND,
    S_FIN
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

  // shift right by n with rounding half away from zero
  function automatic logic signed [ACC_W-1:0] rnd_shr(input logic signed [ACC_W-1:0] v,
                                                     input int unsigned n);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] half;
    logic [ACC_W-1:0] r;
    mag  = v[ACC_W-1] ? -v : v;
    half = ACC_W'(1) << (n - 1);
    r    = (mag + half) >> n;
    return v[ACC_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

@@ rtl/cse_coef_mem.sv @@
// ----------------------------------------------------------------------------
// cse_coef_mem
// Coefficient store: one write port, one registered read port, per-entry
// valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module cse_coef_mem
  import cse_pkg::*;
#(
  parameter int unsigned NUM_COEFS = NUM_COEFS_DEF,
  localparam int unsigned AW = $clog2(NUM_COEFS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_cmd_t          cmd_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0]    mem_q [NUM_COEFS];
  logic [NUM_COEFS-1:0] valid_q;
  logic [DATA_W-1:0]    rd_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

@@ rtl/cse_mul.sv @@
// ----------------------------------------------------------------------------
// cse_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cse_mul
  import cse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/chebyshev_series_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator_core
// Evaluates a Chebyshev series or its derivative at a Q16.16 point.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser = request kind (load / value / derivative), tdata carries
//   coef_index, coef_value and x. A load transaction writes one coefficient slot.
//   An evaluate transaction produces one result transaction
//   on the output stream: tdata = result, tuser = {saturated, out_of_range}.
//   Configuration (order, x_min, x_max, inv_half_span) is written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Datapath:
//   The term products and the recurrence steps run through one shared 33x33
//   multiplier under the sequencer: two multiplies per term but the last, plus
//   rounding the product and accumulating it. The k scaling of a derivative
//   term uses a separate multiply. One evaluation at a time; s_axis_tready is
//   high only while the sequencer is idle.
// Reset: configuration returns to order 1, domain [-1,1], inv_half_span 1.0;
//   every coefficient reads as zero until it is loaded.
// Output stall: the result sits in an output register. The sequencer still
//   takes new transactions while it waits; a second result waits in the final
//   state until the output register is free.
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator_core
  import cse_pkg::*;
#(
  parameter int unsigned NUM_COEFS = NUM_COEFS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [71:0]          s_axis_tdata,  // coef_index[4:0], coef_value[36:5], x[68:37]
  input  logic [REQ_W-1:0]     s_axis_tuser,  // req_type[1:0]
  // master stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,  // result[31:0]
  output logic [1:0]           m_axis_tuser,  // out_of_range[0], saturated[1]
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(NUM_COEFS);

  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32'sh7fff_ffff);
  localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(32'sh8000_0000);

  // --------------------------------------------------------------------------
  // input unpack
  // --------------------------------------------------------------------------
  logic [ORD_W-1:0]         in_idx;
  logic [DATA_W-1:0]        in_coef;
  logic signed [DATA_W-1:0] in_x;
  logic                     accept;

  assign in_idx  = s_axis_tdata[4:0];
  assign in_coef = s_axis_tdata[36:5];
  assign in_x    = s_axis_tdata[68:37];
  assign accept  = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [ORD_W-1:0]         order_q;
  logic signed [DATA_W-1:0] x_min_q;
  logic signed [DATA_W-1:0] x_max_q;
  logic [DATA_W-1:0]        ihs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORD_W'(1);
      x_min_q <= 32'shffff_0000;
      x_max_q <= 32'sh0001_0000;
      ihs_q   <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORDER:         order_q <= cfg_data_i[ORD_W-1:0];
        CFG_X_MIN:         x_min_q <= cfg_data_i;
        CFG_X_MAX:         x_max_q <= cfg_data_i;
        CFG_INV_HALF_SPAN: ihs_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer and datapath state
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic signed [DATA_W-1:0]  x_q;
  logic                      deriv_q;
  logic [ORD_W-1:0]          ord_q;
  logic [ORD_W-1:0]          k_q;
  logic [DATA_W-1:0]         mag_q;
  logic                      neg_q;
  logic [47:0]               hi_q;
  logic signed [T_W-1:0]     t_q;
  logic signed [BASIS_W-1:0] prev_q;
  logic signed [BASIS_W-1:0] cur_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [TERM_W-1:0]  term_q;
  logic signed [RES_W-1:0]   res_q;
  logic                      oor_q;

  logic                      out_valid_q;
  logic [DATA_W-1:0]         out_data_q;
  logic [1:0]                out_user_q;

  // shared units
  mem_cmd_t                 mem_cmd;
  logic [AW-1:0]            mem_rd_addr;
  logic [DATA_W-1:0]        mem_rd_data;
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     out_load;

  cse_coef_mem #(
    .NUM_COEFS (NUM_COEFS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mem_cmd),
    .wr_addr_i (AW'(in_idx)),
    .wr_data_i (in_coef),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  cse_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // --------------------------------------------------------------------------
  // combinational datapath pieces
  // --------------------------------------------------------------------------
  logic              is_eval;
  logic              idx_ok;
  logic [ORD_W-1:0]  ord_lim;
  logic              last_k;

  assign is_eval = s_axis_tuser inside {REQ_VALUE, REQ_DERIV};
  assign idx_ok  = 32'(in_idx) < NUM_COEFS;
  assign ord_lim = (32'(order_q) > NUM_COEFS - 1) ? ORD_W'(NUM_COEFS - 1) : order_q;
  assign last_k  = (k_q == ord_q);

  // range check and point offset d = 2x - x_min - x_max
  logic              oor;
  logic signed [33:0] d;
  logic [33:0]       d_abs;

  assign oor   = (x_q < x_min_q) || (x_q > x_max_q);
  assign d     = (34'(x_q) <<< 1) - 34'(x_min_q) - 34'(x_max_q);
  assign d_abs = d[33] ? -d : d;

  // map to t: clamp when the high partial product already exceeds one
  logic              hi_big;
  logic [49:0]       map_sum;
  logic [49:0]       t_u;
  logic [T_W-1:0]    t_mag;
  logic signed [T_W-1:0] t_new;

  assign hi_big  = |hi_q[47:17];
  assign map_sum = {hi_q[33:0], 16'b0} + {2'b0, prod[47:0]};
  assign t_u     = (map_sum + 50'd64) >> 7;
  assign t_mag   = (hi_big || (t_u > 50'(BASIS_ONE))) ? T_W'(BASIS_ONE) : T_W'(t_u);
  assign t_new   = neg_q ? -$signed(t_mag) : $signed(t_mag);

  // recurrence step B_next = clamp(2 t B - B_prev)
  logic signed [ACC_W-1:0] rec_diff;
  logic signed [ACC_W-1:0] rec_lim;
  logic signed [ACC_W-1:0] rec_clamp;

  assign rec_diff  = rnd_shr(ACC_W'(prod), 25) - ACC_W'(prev_q);
  assign rec_lim   = deriv_q ? (ACC_W'(k_q) <<< FRAC_T) : ACC_W'(BASIS_ONE);
  assign rec_clamp = (rec_diff > rec_lim)  ? rec_lim :
                     (rec_diff < -rec_lim) ? -rec_lim : rec_diff;

  // derivative term times k
  logic signed [45:0] kterm;
  assign kterm = 46'(term_q) * 46'($signed({1'b0, k_q}));

  // final derivative scaling, rounded at 16 bits
  logic [ACC_W-1:0] dscale;
  assign dscale = (acc_q + ACC_W'(32768)) >> 16;

  // saturation
  logic sat_hi;
  logic sat_lo;
  assign sat_hi = res_q > RES_MAX;
  assign sat_lo = res_q < RES_MIN;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && is_eval) state_d = S_CHECK;
      S_CHECK: state_d = oor ? S_FIN : S_MAP1;
      S_MAP1:  state_d = S_MAP2;
      S_MAP2:  state_d = S_MAP3;
      S_MAP3: begin
        if (ord_q == '0) begin
          state_d = deriv_q ? S_DABS : S_VRND;
        end else begin
          state_d = S_TERM;
        end
      end
      S_TERM:  state_d = S_ACC;
      S_ACC: begin
        if (deriv_q) begin
          state_d = S_ACCK;
        end else begin
          state_d = last_k ? S_VRND : S_REC;
        end
      end
      S_ACCK:  state_d = last_k ? S_DABS : S_REC;
      S_REC:   state_d = S_REC2;
      S_REC2:  state_d = S_TERM;
      S_VRND:  state_d = S_FIN;
      S_DABS:  state_d = S_DMLO;
      S_DMLO:  state_d = S_DMHI;
      S_DMHI:  state_d = S_DSUM;
      S_DSUM:  state_d = S_DRND;
      S_DRND:  state_d = S_FIN;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer outputs: handshake, memory and multiplier control
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    mem_cmd       = '0;
    mem_rd_addr   = '0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    out_load      = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        mem_cmd.wr_en = accept && (s_axis_tuser == REQ_LOAD) && idx_ok;
      end
      S_CHECK: begin
        mem_cmd.rd_en = 1'b1;
      end
      S_MAP1: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, mag_q};
        mul_b  = {17'b0, ihs_q[31:16]};
      end
      S_MAP2: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, mag_q};
        mul_b  = {17'b0, ihs_q[15:0]};
      end
      S_MAP3: begin
        mem_cmd.rd_en = 1'b1;
        mem_rd_addr   = AW'(1);
      end
      S_TERM: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'($signed(mem_rd_data));
        mul_b  = MUL_W'(cur_q);
      end
      S_REC: begin
        mem_cmd.rd_en = 1'b1;
        mem_rd_addr   = AW'(k_q);
        mul_en        = 1'b1;
        mul_a         = MUL_W'(t_q);
        mul_b         = MUL_W'(cur_q);
      end
      S_DMLO: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, acc_q[31:0]};
        mul_b  = {1'b0, ihs_q};
      end
      S_DMHI: begin
        mul_en = 1'b1;
        mul_a  = {17'b0, acc_q[47:32]};
        mul_b  = {1'b0, ihs_q};
      end
      S_FIN: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          x_q     <= in_x;
          deriv_q <= (s_axis_tuser == REQ_DERIV);
          ord_q   <= ord_lim;
        end
      end
      S_CHECK: begin
        oor_q <= oor;
        res_q <= '0;
        mag_q <= d_abs[31:0];
        neg_q <= d[33];
      end
      S_MAP3: begin
        t_q <= t_new;
        k_q <= ORD_W'(1);
        if (deriv_q) begin
          acc_q  <= '0;
          prev_q <= '0;
          cur_q  <= BASIS_ONE;
        end else begin
          acc_q  <= ACC_W'($signed(mem_rd_data)) <<< 25;
          prev_q <= BASIS_ONE;
          cur_q  <= BASIS_W'(t_new);
        end
      end
      S_MAP2: begin
        hi_q <= prod[47:0];
      end
      S_ACC: begin
        if (deriv_q) begin
          term_q <= TERM_W'(rnd_shr(ACC_W'(prod), FRAC_T));
        end else begin
          acc_q <= acc_q + ACC_W'(prod);
          if (!last_k) k_q <= k_q + ORD_W'(1);
        end
      end
      S_ACCK: begin
        acc_q <= acc_q + ACC_W'(kterm);
        if (!last_k) k_q <= k_q + ORD_W'(1);
      end
      S_REC2: begin
        prev_q <= cur_q;
        cur_q  <= BASIS_W'(rec_clamp);
      end
      S_VRND: begin
        res_q <= RES_W'(rnd_shr(acc_q, FRAC_T));
      end
      S_DABS: begin
        neg_q <= acc_q[ACC_W-1];
        acc_q <= acc_q[ACC_W-1] ? -acc_q : acc_q;
      end
      S_DMHI: begin
        acc_q <= ACC_W'(prod);
      end
      S_DSUM: begin
        acc_q <= acc_q + (ACC_W'(prod) <<< 32);
      end
      S_DRND: begin
        res_q <= neg_q ? -$signed(RES_W'(dscale)) : $signed(RES_W'(dscale));
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= sat_hi ? 32'h7fff_ffff : sat_lo ? 32'h8000_0000 : res_q[DATA_W-1:0];
      out_user_q <= {sat_hi || sat_lo, oor_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ rtl/cse_checker.sv @@
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks for the Chebyshev series evaluator, bound to the top.
// ----------------------------------------------------------------------------
module cse_checker
  import cse_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [71:0]          s_axis_tdata,
  input logic [REQ_W-1:0]     s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [DATA_W-1:0]    m_axis_tdata,
  input logic [1:0]           m_axis_tuser,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [DATA_W-1:0]    cfg_data_i
);

  // evaluation occupies the sequencer
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tuser == REQ_VALUE || s_axis_tuser == REQ_DERIV) |=> !s_axis_tready)
    else $error("ready stayed high after an evaluate transaction");

  // loads and unused kinds leave the sequencer ready
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
    !(s_axis_tuser == REQ_VALUE || s_axis_tuser == REQ_DERIV) |=> s_axis_tready)
    else $error("ready dropped after a load transaction");

  // out-of-range result is zero and not clipped
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
    else $error("out-of-range result not zero");

  // a clipped result sits at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
    (m_axis_tdata == 32'h7fff_ffff) || (m_axis_tdata == 32'h8000_0000))
    else $error("saturated result not at a rail");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind chebyshev_series_evaluator_core cse_checker u_cse_checker (.*);

@@ dv/tb_chebyshev_series_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// tb_chebyshev_series_evaluator_core
// Self-checking bench for the Chebyshev series evaluator core. Loads random
// coefficient sets and sends value and derivative requests over the input
// stream. A bit-exact scoreboard predicts every result and compares it with
// the output stream. Domain and order settings change between phases.
// ----------------------------------------------------------------------------
module tb_chebyshev_series_evaluator_core;
  import cse_pkg::*;

  // reserved request kind, the core drops it without a result
  localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;
  // margin past the longest evaluation, rounded up for the output register
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS  = 112;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the coefficient store and config registers,
  // plus a FIFO of predicted result transactions.
  // --------------------------------------------------------------------------
  class cheb_scoreboard;
    typedef struct {
      logic [31:0] result;
      logic        out_of_range;
      logic        saturated;
    } result_t;

    logic signed [31:0] coefs [32];
    logic        [4:0]  order_reg;
    logic signed [31:0] x_lo;
    logic signed [31:0] x_hi;
    logic        [31:0] ihs;
    result_t            pending_results [$];
    int unsigned        errors;

    function new();
      foreach (coefs[i]) coefs[i] = '0;
      order_reg = 5'd1;
      x_lo      = 32'hFFFF_0000;
      x_hi      = 32'h0001_0000;
      ihs       = 32'h0001_0000;
      errors    = 0;
    endfunction

    task report(string msg);
      // keep the log short on a badly broken build
      if (errors < 100) $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        CFG_ORDER:         order_reg = val[4:0];
        CFG_X_MIN:         x_lo      = val;
        CFG_X_MAX:         x_hi      = val;
        CFG_INV_HALF_SPAN: ihs       = val;
        default: ;
      endcase
    endfunction

    // shift right by n, rounding half away from zero
    function longint rnd_away(longint v, int unsigned n);
      longint half;
      half = longint'(1) << (n - 1);
      if (v >= 0) return (v + half) >>> n;
      return -((-v + half) >>> n);
    endfunction

    function longint clamp_mag(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // t = |d| * inv_half_span / 2^7, 26 fraction bits, clamped to [-1,1]
    function longint map_point(longint d);
      longint unsigned mag, hi_part, prod, t;
      mag     = (d < 0) ? 64'(-d) : 64'(d);
      hi_part = mag * 64'(ihs[31:16]);
      if (hi_part >= 64'd131072) begin
        t = 64'(BASIS_ONE);
      end else begin
        prod = (hi_part << 16) + mag * 64'(ihs[15:0]);
        t    = (prod + 64'd64) >> 7;
        if (t > 64'(BASIS_ONE)) t = 64'(BASIS_ONE);
      end
      return (d < 0) ? -longint'(t) : longint'(t);
    endfunction

    // c0/2 + sum c[k]*T_k(t), exact accumulation at 42 fraction bits
    function result_t value_sum(longint t, int unsigned ord);
      result_t res;
      longint  unit, acc, prev, cur, nxt, r;
      unit = longint'(BASIS_ONE);
      res  = '{default: '0};
      acc  = longint'(coefs[0]) * (longint'(1) << 25);
      prev = unit;
      cur  = t;
      for (int unsigned k = 1; k <= ord; k++) begin
        if (k >= 2) begin
          nxt  = clamp_mag(rnd_away(t * cur, 25) - prev, unit);
          prev = cur;
          cur  = nxt;
        end
        acc += longint'(coefs[k]) * cur;
      end
      r = rnd_away(acc, 26);
      if (r > longint'(32'sh7FFF_FFFF)) begin
        res.result    = 32'h7FFF_FFFF;
        res.saturated = 1'b1;
      end else if (r < longint'(32'sh8000_0000)) begin
        res.result    = 32'h8000_0000;
        res.saturated = 1'b1;
      end else begin
        res.result = r[31:0];
      end
      return res;
    endfunction

    // inv_half_span * sum k*c[k]*U_{k-1}(t), each term rounded to Q16.16
    function result_t deriv_sum(longint t, int unsigned ord);
      result_t         res;
      longint          unit, sum, u, ulast, nxt;
      longint unsigned mag, r;
      unit  = longint'(BASIS_ONE);
      res   = '{default: '0};
      sum   = 0;
      u     = unit;
      ulast = 0;
      for (int unsigned k = 1; k <= ord; k++) begin
        if (k >= 2) begin
          nxt   = clamp_mag(rnd_away(t * u, 25) - ulast, longint'(k) * unit);
          ulast = u;
          u     = nxt;
        end
        sum += longint'(k) * rnd_away(longint'(coefs[k]) * u, 26);
      end
      mag = (sum < 0) ? 64'(-sum) : 64'(sum);
      r   = mag * 64'(ihs[31:16]) + ((mag * 64'(ihs[15:0]) + 64'h8000) >> 16);
      if (sum >= 0) begin
        if (r > 64'h7FFF_FFFF) begin
          res.result    = 32'h7FFF_FFFF;
          res.saturated = 1'b1;
        end else begin
          res.result = r[31:0];
        end
      end else if (r > 64'h8000_0000) begin
        res.result    = 32'h8000_0000;
        res.saturated = 1'b1;
      end else begin
        res.result = 32'(-r);
      end
      return res;
    endfunction

    // accepted input transaction: update the store or queue a prediction
    function void note_input(logic [REQ_W-1:0] kind, logic [4:0] idx,
                             logic [31:0] val, logic [31:0] xv);
      result_t want;
      longint  xs, t;
      if (kind == REQ_LOAD) begin
        coefs[idx] = val;
        return;
      end
      if (kind != REQ_VALUE && kind != REQ_DERIV) return;
      want = '{default: '0};
      xs   = longint'($signed(xv));
      if (xs < longint'(x_lo) || xs > longint'(x_hi)) begin
        // reversed domain lands here for every point
        want.out_of_range = 1'b1;
      end else begin
        t = map_point(2 * xs - longint'(x_lo) - longint'(x_hi));
        want = (kind == REQ_VALUE) ? value_sum(t, order_reg) : deriv_sum(t, order_reg);
      end
      pending_results.push_back(want);
    endfunction

    task check_result(logic [31:0] data, logic [1:0] user);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h / %b with no request pending", data, user));
        return;
      end
      want = pending_results.pop_front();
      if (data !== want.result)
        report($sformatf("result %h, predicted %h", data, want.result));
      if (user[0] !== want.out_of_range)
        report($sformatf("out_of_range %b, predicted %b", user[0], want.out_of_range));
      if (user[1] !== want.saturated)
        report($sformatf("saturated %b, predicted %b", user[1], want.saturated));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [71:0]          s_axis_tdata;   // coef_index[4:0], coef_value[36:5], x[68:37]
  logic [REQ_W-1:0]     s_axis_tuser;   // req_type[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;   // result[31:0]
  logic [1:0]           m_axis_tuser;   // out_of_range[0], saturated[1]
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  cheb_scoreboard sb;
  int unsigned    src_idle_pct;   // chance of a gap before each input transaction
  int unsigned    sink_idle_pct;  // chance of tready low on any cycle

  chebyshev_series_evaluator_core #(
    .NUM_COEFS(NUM_COEFS_DEF)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random backpressure, rate set per phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: outputs are checked before the same-edge input is noted, a
  // result can never belong to a request accepted on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[36:5],
                      s_axis_tdata[68:37]);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered right after a rising edge.
  // --------------------------------------------------------------------------

  // One input transaction, with an optional idle gap in front of it.
  task automatic send_item(logic [REQ_W-1:0] kind, logic [4:0] idx,
                           logic [31:0] val, logic [31:0] xv);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      // mostly short gaps, now and then a longer one that can outlast a low-order evaluation
      repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 60 : 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, xv, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off the sender until every predicted result is out, then let the
  // core finish any trailing load.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_domain(logic [4:0] ord, logic [31:0] lo, logic [31:0] hi,
                            logic [31:0] ihs_v);
    drain();
    write_reg(CFG_ORDER, 32'(ord));
    write_reg(CFG_X_MIN, lo);
    write_reg(CFG_X_MAX, hi);
    write_reg(CFG_INV_HALF_SPAN, ihs_v);
    cfg_we_i <= 1'b0;
  endtask

  // Random transaction: mostly loads and in-domain evaluations, some points
  // on or just past the domain edges, some raw noise and reserved kinds.
  task automatic random_item();
    logic [REQ_W-1:0] kind;
    logic [4:0]       idx;
    logic [31:0]      val;
    logic [31:0]      xv;
    longint           lo, hi, span;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 30)      kind = REQ_LOAD;
    else if (pick < 62) kind = REQ_VALUE;
    else if (pick < 95) kind = REQ_DERIV;
    else                kind = REQ_RSVD;
    idx = 5'($urandom_range(31));
    case ($urandom_range(3))
      0:       val = $urandom;                                         // full range
      1:       val = 32'($urandom_range(32'h0001_0000)) - 32'h0000_8000; // +-0.5
      default: val = 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000; // +-4
    endcase
    lo   = longint'(sb.x_lo);
    hi   = longint'(sb.x_hi);
    span = hi - lo + 1;
    pick = $urandom_range(99);
    if (span > 0 && pick < 75)
      xv = 32'(lo + longint'({$urandom, $urandom} % span));
    else if (pick < 83)
      xv = $urandom_range(1) ? 32'(lo) : 32'(hi);
    else if (pick < 90)
      xv = $urandom_range(1) ? 32'(lo - 1) : 32'(hi + 1);
    else
      xv = $urandom;
    send_item(kind, idx, val, xv);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) random_item();
  endtask

  // Reset config: order 1, domain [-1,1], inv_half_span 1.0.
  task automatic directed_items();
    send_item(REQ_LOAD,  5'd0,  32'h7FFF_FFFF, 32'h0000_0000);
    send_item(REQ_LOAD,  5'd1,  32'h8000_0000, 32'hFFFF_FFFF);
    send_item(REQ_LOAD,  5'd31, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(REQ_VALUE, 5'd0,  32'h0000_0000, 32'hFFFF_0000);  // at x_min
    send_item(REQ_VALUE, 5'd0,  32'h0000_0000, 32'h0001_0000);  // at x_max
    send_item(REQ_VALUE, 5'd0,  32'h0000_0000, 32'h0000_0000);
    send_item(REQ_DERIV, 5'd0,  32'h0000_0000, 32'h0001_0000);  // -2^31, no clip
    send_item(REQ_DERIV, 5'd0,  32'h0000_0000, 32'hFFFF_0000);
    send_item(REQ_DERIV, 5'd0,  32'h0000_0000, 32'h0000_0000);
    // just outside, and the extremes of x
    send_item(REQ_VALUE, 5'd0,  32'h0000_0000, 32'h0001_0001);
    send_item(REQ_DERIV, 5'd0,  32'h0000_0000, 32'hFFFE_FFFF);
    send_item(REQ_VALUE, 5'd31, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(REQ_DERIV, 5'd31, 32'hFFFF_FFFF, 32'h8000_0000);
    // reserved kind: dropped, no result
    send_item(REQ_RSVD,  5'd31, 32'hFFFF_FFFF, 32'h0000_0000);
    // drive the sum past both 32-bit limits
    send_item(REQ_LOAD,  5'd1,  32'h7FFF_FFFF, 32'h0000_0000);
    send_item(REQ_VALUE, 5'd0,  32'h0000_0000, 32'h0001_0000);
    send_item(REQ_DERIV, 5'd0,  32'h0000_0000, 32'h0000_0000);
    send_item(REQ_LOAD,  5'd0,  32'h8000_0000, 32'h0000_0000);
    send_item(REQ_LOAD,  5'd1,  32'h8000_0000, 32'h0000_0000);
    send_item(REQ_VALUE, 5'd0,  32'h0000_0000, 32'h0001_0000);
    send_item(REQ_VALUE, 5'd0,  32'h0000_0000, 32'hFFFF_0000);
  endtask

  // Run limit, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_LOAD;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ORDER;
    cfg_data_i    = '0;
    src_idle_pct  = 14;
    sink_idle_pct = 57;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender lightly idle, receiver stalls often
    directed_items();
    run_random(PHASE_ITEMS);
    set_domain(5'd31, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
    run_random(PHASE_ITEMS);
    // order zero: value is c0/2, derivative is zero
    set_domain(5'd0, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
    run_random(PHASE_ITEMS);

    // sender idles often, receiver lightly
    src_idle_pct  = 57;
    sink_idle_pct = 14;
    // reversed domain, every evaluation flags out of range
    set_domain(5'd5, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    run_random(PHASE_ITEMS);
    // widest domain with the largest scale, t clamps to the ends except near the middle
    set_domain(5'd31, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    run_random(PHASE_ITEMS);

    // no idling on either side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_domain(5'd9, 32'hFFFC_0000, 32'h000C_0000, 32'h0000_2000);   // [-4,12]
    run_random(PHASE_ITEMS);
    set_domain(5'd17, 32'h0000_0000, 32'h0000_8000, 32'h0004_0000);  // [0,0.5]
    run_random(PHASE_ITEMS);
    set_domain(5'd3, 32'hFFFE_0000, 32'h0002_0000, 32'h0000_0000);   // zero scale
    run_random(PHASE_ITEMS);

    drain();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cse_pkg.sv
rtl/cse_coef_mem.sv
rtl/cse_mul.sv
rtl/chebyshev_series_evaluator_core.sv
rtl/cse_checker.sv
dv/tb_chebyshev_series_evaluator_core.sv
